### rtl/core/rspd_pkg.sv
// Package for the RSP packet deframer: character codes, event codes and the
// hex decode result type. No dependencies.
package rspd_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_NONE   = 8'h00;

  localparam logic [3:0] EV_PAYLOAD    = 4'd0;
  localparam logic [3:0] EV_ACCEPTED   = 4'd1;
  localparam logic [3:0] EV_BAD_HEX    = 4'd2;
  localparam logic [3:0] EV_MISMATCH   = 4'd3;
  localparam logic [3:0] EV_IGNORED    = 4'd4;
  localparam logic [3:0] EV_HOST_ACK   = 4'd5;
  localparam logic [3:0] EV_HOST_NACK  = 4'd6;
  localparam logic [3:0] EV_STRAY_ACK  = 4'd7;
  localparam logic [3:0] EV_STRAY_NACK = 4'd8;
  localparam logic [3:0] EV_UNEXPECTED = 4'd9;

  // Decoded checksum: ok is set only when both digits are lowercase hex.
  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } hex_t;

endpackage

### rtl/core/rspd_if.sv
// Valid/ready channel interfaces for the RSP packet deframer.
// Depends on nothing; one interface for received bytes, one for results.
interface rspd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rspd_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  tx_byte;
  logic [15:0] payload_length;
  logic [7:0]  received_checksum;
  logic [7:0]  computed_checksum;

  modport source (output valid, output event_res, output data_byte, output tx_byte,
                  output payload_length, output received_checksum,
                  output computed_checksum, input ready);
  modport sink (input valid, input event_res, input data_byte, input tx_byte,
                input payload_length, input received_checksum,
                input computed_checksum, output ready);
endinterface

### rtl/core/rspd_hex_pair.sv
// Decodes the two checksum characters of a frame into one byte.
// Depends on rspd_pkg for the result type.
module rspd_hex_pair (
  input  logic [7:0]    hi_char,
  input  logic [7:0]    lo_char,
  output rspd_pkg::hex_t result
);

  // Nibble value of one character; bit 4 flags a valid lowercase hex digit.
  function automatic logic [4:0] nibble(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
        nibble = {1'b1, d[3:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        nibble = {1'b1, d[3:0]};
      end else begin
        nibble = 5'd0;
      end
    end
  endfunction

  logic [4:0] hi_nib;
  logic [4:0] lo_nib;

  assign hi_nib = nibble(hi_char);
  assign lo_nib = nibble(lo_char);

  always_comb begin
    result.ok    = hi_nib[4] & lo_nib[4];
    result.value = result.ok ? {hi_nib[3:0], lo_nib[3:0]} : 8'h00;
  end

endmodule

### rtl/core/rsp_packet_deframer_ack.sv
// Top level of the RSP packet deframer with host ACK tracking.
// Depends on rspd_pkg, rspd_if.sv and rspd_hex_pair.
//
// Usage:
//   Received serial bytes enter on the rx channel, one byte per transaction.
//   Each byte yields zero or one result transaction on the res channel: a
//   forwarded payload byte, a frame verdict with the byte to transmit
//   ('+' or '-'), or a report on host ACK/NACK and stray bytes. The '$' that
//   opens a frame, the '#' that ends the payload and the first checksum
//   digit produce no result.
//
//   Throughput is one byte per cycle while the receiver takes results. A byte
//   accepted at a clock edge is held in the input register and then processed
//   into the result register, from which its result is offered. The frame
//   state update for each byte sets this rate.
//
//   Reset (rst, synchronous, active high) returns the block to idle between
//   frames with no response waiting for an ACK, and empties both registers.
//
//   When the receiver stalls, the result register holds its transaction; the
//   input register still advances for bytes that produce no result, and
//   otherwise holds, so rx.ready drops until the result is taken. Nothing is
//   lost or repeated.
module rsp_packet_deframer_ack (
  input logic              clk,
  input logic              rst,
  rspd_rx_if.sink          rx_chan,
  rspd_res_if.source       res_chan
);

  // Frame phase codes.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DIGIT1  = 2'd2;
  localparam logic [1:0] PH_DIGIT2  = 2'd3;

  // Frame state.
  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [7:0]  running_sum;
  logic [7:0]  running_sum_next;
  logic [7:0]  first_digit;
  logic [7:0]  first_digit_next;
  logic [15:0] length_count;
  logic [15:0] length_count_next;
  logic        awaiting_ack;
  logic        awaiting_ack_next;

  // Input register.
  logic        s1_valid;
  logic [7:0]  s1_byte;

  // Result register.
  logic        res_valid;
  logic [3:0]  res_event;
  logic [7:0]  res_data;
  logic [7:0]  res_tx;
  logic [15:0] res_len;
  logic [7:0]  res_rcv;
  logic [7:0]  res_cmp;

  // Result computed from the held byte.
  logic        has_result;
  logic [3:0]  ev_next;
  logic [7:0]  data_next;
  logic [7:0]  tx_next;
  logic [15:0] len_next;
  logic [7:0]  rcv_next;
  logic [7:0]  cmp_next;

  logic        slot_free;
  logic        s1_fire;

  rspd_pkg::hex_t checksum;

  rspd_hex_pair u_hex (
    .hi_char (first_digit),
    .lo_char (s1_byte),
    .result  (checksum)
  );

  // The held byte moves on when its result, if any, has room.
  assign slot_free    = !res_valid || res_chan.ready;
  assign s1_fire      = s1_valid && (!has_result || slot_free);
  assign rx_chan.ready = !s1_valid || s1_fire;

  always_comb begin
    phase_next        = phase;
    running_sum_next  = running_sum;
    first_digit_next  = first_digit;
    length_count_next = length_count;
    awaiting_ack_next = awaiting_ack;
    has_result        = 1'b0;
    ev_next           = rspd_pkg::EV_UNEXPECTED;
    data_next         = 8'h00;
    tx_next           = rspd_pkg::CH_NONE;
    len_next          = 16'h0000;
    rcv_next          = 8'h00;
    cmp_next          = 8'h00;
    case (phase)
      PH_IDLE: begin
        if (s1_byte == rspd_pkg::CH_DOLLAR) begin
          running_sum_next  = 8'h00;
          length_count_next = 16'h0000;
          phase_next        = PH_PAYLOAD;
        end else if (s1_byte == rspd_pkg::CH_PLUS) begin
          has_result = 1'b1;
          if (awaiting_ack) begin
            awaiting_ack_next = 1'b0;
            ev_next           = rspd_pkg::EV_HOST_ACK;
          end else begin
            ev_next = rspd_pkg::EV_STRAY_ACK;
          end
        end else if (s1_byte == rspd_pkg::CH_MINUS) begin
          has_result = 1'b1;
          ev_next    = awaiting_ack ? rspd_pkg::EV_HOST_NACK : rspd_pkg::EV_STRAY_NACK;
        end else begin
          has_result = 1'b1;
          ev_next    = rspd_pkg::EV_UNEXPECTED;
        end
      end
      PH_PAYLOAD: begin
        if (s1_byte == rspd_pkg::CH_HASH) begin
          phase_next = PH_DIGIT1;
        end else begin
          running_sum_next = running_sum + s1_byte;
          if (length_count != 16'hFFFF) begin
            length_count_next = length_count + 16'd1;
          end
          has_result = 1'b1;
          ev_next    = rspd_pkg::EV_PAYLOAD;
          data_next  = s1_byte;
        end
      end
      PH_DIGIT1: begin
        first_digit_next = s1_byte;
        phase_next       = PH_DIGIT2;
      end
      default: begin
        // Second checksum digit: judge the frame.
        phase_next = PH_IDLE;
        has_result = 1'b1;
        len_next   = length_count;
        cmp_next   = running_sum;
        rcv_next   = checksum.value;
        if (awaiting_ack) begin
          ev_next = rspd_pkg::EV_IGNORED;
        end else if (!checksum.ok) begin
          ev_next = rspd_pkg::EV_BAD_HEX;
          tx_next = rspd_pkg::CH_MINUS;
        end else if (checksum.value != running_sum) begin
          ev_next = rspd_pkg::EV_MISMATCH;
          tx_next = rspd_pkg::CH_MINUS;
        end else begin
          ev_next           = rspd_pkg::EV_ACCEPTED;
          tx_next           = rspd_pkg::CH_PLUS;
          awaiting_ack_next = 1'b1;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      running_sum  <= 8'h00;
      first_digit  <= 8'h00;
      length_count <= 16'h0000;
      awaiting_ack <= 1'b0;
      s1_valid     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (s1_fire) begin
        phase        <= phase_next;
        running_sum  <= running_sum_next;
        first_digit  <= first_digit_next;
        length_count <= length_count_next;
        awaiting_ack <= awaiting_ack_next;
      end
      if (rx_chan.valid && rx_chan.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && has_result) begin
        res_valid <= 1'b1;
      end else if (res_chan.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rx_chan.valid && rx_chan.ready) begin
      s1_byte <= rx_chan.rx_byte;
    end
    if (s1_fire && has_result) begin
      res_event <= ev_next;
      res_data  <= data_next;
      res_tx    <= tx_next;
      res_len   <= len_next;
      res_rcv   <= rcv_next;
      res_cmp   <= cmp_next;
    end
  end

  assign res_chan.valid             = res_valid;
  assign res_chan.event_res         = res_event;
  assign res_chan.data_byte         = res_data;
  assign res_chan.tx_byte           = res_tx;
  assign res_chan.payload_length    = res_len;
  assign res_chan.received_checksum = res_rcv;
  assign res_chan.computed_checksum = res_cmp;

endmodule

### rtl/core/rspd_checker.sv
// Port-level assertions for rsp_packet_deframer_ack, bound to the top level.
// Depends on rspd_pkg for event and character codes.
module rspd_port_assert (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [3:0]  event_res,
  input logic [7:0]  data_byte,
  input logic [7:0]  tx_byte
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // Only an accepted frame transmits '+'.
  a_plus: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((event_res == rspd_pkg::EV_ACCEPTED) == (tx_byte == rspd_pkg::CH_PLUS)))
    else $error("'+' not tied to an accepted frame");

  // '-' goes out exactly for a bad or mismatched checksum.
  a_minus: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (((event_res == rspd_pkg::EV_BAD_HEX) ||
                    (event_res == rspd_pkg::EV_MISMATCH)) == (tx_byte == rspd_pkg::CH_MINUS)))
    else $error("'-' not tied to a rejected frame");

  // Forwarded data appears only with payload events.
  a_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res != rspd_pkg::EV_PAYLOAD) |-> (data_byte == 8'h00))
    else $error("data byte set outside a payload event");

endmodule

bind rsp_packet_deframer_ack rspd_port_assert u_rspd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_chan.valid),
  .res_ready (res_chan.ready),
  .event_res (res_chan.event_res),
  .data_byte (res_chan.data_byte),
  .tx_byte   (res_chan.tx_byte)
);

### tb/rspd_checker.sv
`timescale 1ns / 100ps
// Result checker for the RSP packet deframer: predicts every result from the
// received bytes and compares it with what the block delivers. Uses rspd_pkg and rspd_if.sv.
module rspd_checker (
  input  logic        clk,
  input  logic        rst,
  rspd_rx_if          rx_mon,
  rspd_res_if         res_mon,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);

  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] DIGIT_9 = 8'h39;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_F = 8'h66;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum logic [1:0] {
    BETWEEN_FRAMES,
    IN_PAYLOAD,
    AWAIT_DIGIT_HI,
    AWAIT_DIGIT_LO
  } frame_phase_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic [7:0]  data;
    logic [7:0]  tx;
    logic [15:0] len;
    logic [7:0]  rcv;
    logic [7:0]  cmp;
  } deframe_result_t;

  frame_phase_t    phase;
  logic [7:0]      sum_acc;
  logic [7:0]      hi_digit;
  logic [15:0]     byte_count;
  logic            ack_pending;
  deframe_result_t expected_q[$];
  int unsigned     fail_total;

  // Bit 4 flags a lowercase hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= DIGIT_0 && c <= DIGIT_9) begin
      v = c - DIGIT_0;
      return {1'b1, v[3:0]};
    end
    if (c >= LOWER_A && c <= LOWER_F) begin
      v = c - LOWER_A + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'b0;
  endfunction

  function automatic rspd_pkg::hex_t decode_checksum(input logic [7:0] hi,
                                                     input logic [7:0] lo);
    logic [4:0]     h;
    logic [4:0]     l;
    rspd_pkg::hex_t d;
    h = nibble_of(hi);
    l = nibble_of(lo);
    d.ok = h[4] & l[4];
    d.value = d.ok ? {h[3:0], l[3:0]} : 8'h00;
    return d;
  endfunction

  // Advances the frame state by one received byte and queues its result, if any.
  task automatic deframe_byte(input logic [7:0] b);
    deframe_result_t r;
    rspd_pkg::hex_t  ck;
    logic            emits;
    r = '0;
    emits = 1'b1;
    case (phase)
      BETWEEN_FRAMES: begin
        if (b == rspd_pkg::CH_DOLLAR) begin
          sum_acc = 8'h00;
          byte_count = 16'h0000;
          phase = IN_PAYLOAD;
          emits = 1'b0;
        end else if (b == rspd_pkg::CH_PLUS) begin
          r.ev = ack_pending ? rspd_pkg::EV_HOST_ACK : rspd_pkg::EV_STRAY_ACK;
          ack_pending = 1'b0;
        end else if (b == rspd_pkg::CH_MINUS) begin
          r.ev = ack_pending ? rspd_pkg::EV_HOST_NACK : rspd_pkg::EV_STRAY_NACK;
        end else begin
          r.ev = rspd_pkg::EV_UNEXPECTED;
        end
      end
      IN_PAYLOAD: begin
        if (b == rspd_pkg::CH_HASH) begin
          phase = AWAIT_DIGIT_HI;
          emits = 1'b0;
        end else begin
          sum_acc = sum_acc + b;
          if (byte_count != LEN_MAX) byte_count = byte_count + 16'd1;
          r.ev = rspd_pkg::EV_PAYLOAD;
          r.data = b;
        end
      end
      AWAIT_DIGIT_HI: begin
        hi_digit = b;
        phase = AWAIT_DIGIT_LO;
        emits = 1'b0;
      end
      default: begin
        ck = decode_checksum(hi_digit, b);
        phase = BETWEEN_FRAMES;
        r.len = byte_count;
        r.cmp = sum_acc;
        r.rcv = ck.value;
        if (ack_pending) begin
          r.ev = rspd_pkg::EV_IGNORED;
        end else if (!ck.ok) begin
          r.ev = rspd_pkg::EV_BAD_HEX;
          r.tx = rspd_pkg::CH_MINUS;
        end else if (ck.value != sum_acc) begin
          r.ev = rspd_pkg::EV_MISMATCH;
          r.tx = rspd_pkg::CH_MINUS;
        end else begin
          r.ev = rspd_pkg::EV_ACCEPTED;
          r.tx = rspd_pkg::CH_PLUS;
          ack_pending = 1'b1;
        end
      end
    endcase
    if (emits) expected_q = {expected_q, r};
  endtask

  always @(posedge clk) begin
    deframe_result_t got;
    deframe_result_t want;
    if (rst) begin
      phase = BETWEEN_FRAMES;
      sum_acc = 8'h00;
      hi_digit = 8'h00;
      byte_count = 16'h0000;
      ack_pending = 1'b0;
      expected_q.delete();
      fail_total = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got = {res_mon.event_res, res_mon.data_byte, res_mon.tx_byte,
               res_mon.payload_length, res_mon.received_checksum,
               res_mon.computed_checksum};
        if (expected_q.size() == 0) begin
          if (fail_total < REPORT_LIMIT)
            $display("[%0t] result with nothing expected: %s", $time,
                     $sformatf("ev=%0d data=%02h tx=%02h len=%0d rcv=%02h cmp=%02h",
                               got.ev, got.data, got.tx, got.len, got.rcv, got.cmp));
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_total < REPORT_LIMIT) begin
              $display("[%0t] mismatch: expected %s", $time,
                       $sformatf("ev=%0d data=%02h tx=%02h len=%0d rcv=%02h cmp=%02h",
                                 want.ev, want.data, want.tx, want.len, want.rcv,
                                 want.cmp));
              $display("[%0t] mismatch: got      %s", $time,
                       $sformatf("ev=%0d data=%02h tx=%02h len=%0d rcv=%02h cmp=%02h",
                                 got.ev, got.data, got.tx, got.len, got.rcv, got.cmp));
            end
            fail_total++;
          end
        end
      end
      if (rx_mon.valid && rx_mon.ready) deframe_byte(rx_mon.rx_byte);
    end
    mismatch_count <= fail_total;
    outstanding <= expected_q.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the RSP packet deframer testbench: clock, reset, byte stimulus and
// result back-pressure. Uses rspd_pkg, rspd_if.sv, rspd_checker and the block.
module tb;

  // A generous ceiling on the whole run; a correct run takes a small fraction.
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned RANDOM_ITEMS = 1000;
  // Length of the directed gapless frame: a long run of back-to-back payload bytes.
  localparam int unsigned LONG_FRAME_LEN = 100;
  // Receiver hold-off that fills the block and forces rx.ready low.
  localparam int unsigned HOLD_CYCLES = 300;
  // Acceptance to result spans the input and result registers; this leaves plenty of margin.
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] HEX_A_BIAS = 8'h57;  // 'a' minus 10

  typedef enum {CK_GOOD, CK_WRONG, CK_BAD} cksum_kind_t;

  logic        clk;
  logic        rst;
  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned bytes_sent;
  bit          sender_gapless;
  bit          hold_request;

  rspd_rx_if  rx_chan ();
  rspd_res_if res_chan ();

  rsp_packet_deframer_ack u_top (
    .clk      (clk),
    .rst      (rst),
    .rx_chan  (rx_chan),
    .res_chan (res_chan)
  );

  // The checker watches both channels, keeps its own copy of the frame state
  // and counts every wrong, surplus or missing result.
  rspd_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .rx_mon         (rx_chan),
    .res_mon        (res_chan),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths: most are zero or short, a few are long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? DIGIT_0 + n : HEX_A_BIAS + n;
  endfunction

  // Offers one byte on rx and returns at the edge where the transaction is taken.
  // valid stays high straight into the next byte when there is no gap.
  task automatic send_byte(input logic [7:0] b);
    int unsigned idle;
    idle = sender_gapless ? 0 : pick_gap();
    if (idle > 0) begin
      rx_chan.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    rx_chan.valid <= 1'b1;
    rx_chan.rx_byte <= b;
    do @(posedge clk); while (!rx_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // A payload byte that never closes the frame early. The framing characters
  // show up often, since inside a frame they are plain payload.
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = rspd_pkg::CH_DOLLAR;
      1: b = rspd_pkg::CH_PLUS;
      2: b = rspd_pkg::CH_MINUS;
      default: begin
        do b = 8'($urandom_range(0, 255)); while (b == rspd_pkg::CH_HASH);
      end
    endcase
    return b;
  endfunction

  // Sends a complete frame whose checksum is right, wrong, or not valid hex.
  task automatic send_frame(input int unsigned len, input cksum_kind_t kind);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] wrong;
    logic [7:0] hi;
    logic [7:0] lo;
    sum = 8'h00;
    send_byte(rspd_pkg::CH_DOLLAR);
    for (int unsigned i = 0; i < len; i++) begin
      b = payload_byte();
      sum = sum + b;
      send_byte(b);
    end
    send_byte(rspd_pkg::CH_HASH);
    hi = hex_digit(sum[7:4]);
    lo = hex_digit(sum[3:0]);
    if (kind == CK_WRONG) begin
      do wrong = 8'($urandom_range(0, 255)); while (wrong == sum);
      hi = hex_digit(wrong[7:4]);
      lo = hex_digit(wrong[3:0]);
    end else if (kind == CK_BAD) begin
      // Characters just outside the digit ranges, uppercase hex, or anything.
      case ($urandom_range(0, 5))
        0: b = 8'h2F;
        1: b = 8'h3A;
        2: b = 8'h60;
        3: b = 8'h67;
        4: b = 8'h41 + 8'($urandom_range(0, 5));
        default: b = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 2))
        0: hi = b;
        1: lo = b;
        default: begin
          hi = b;
          lo = 8'($urandom_range(0, 255));
        end
      endcase
    end
    send_byte(hi);
    send_byte(lo);
  endtask

  // Result side: random stretches of ready and stall, interrupted once by a
  // long hold-off while the sender keeps offering bytes.
  initial begin : result_sink
    int unsigned stretch;
    logic        level;
    res_chan.ready <= 1'b0;
    stretch = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        level = 1'b0;
        stretch = HOLD_CYCLES;
      end else if (stretch == 0) begin
        if ($urandom_range(0, 9) < 6) begin
          level = 1'b1;
          stretch = $urandom_range(1, 40);
        end else begin
          level = 1'b0;
          stretch = pick_gap() + 1;
        end
      end
      res_chan.ready <= level;
      stretch--;
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned r;
    cksum_kind_t kind;
    rst <= 1'b1;
    rx_chan.valid <= 1'b0;
    rx_chan.rx_byte <= 8'h00;
    bytes_sent = 0;
    sender_gapless = 1'b0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Host replies with nothing outstanding are stray, and a
    // byte outside the protocol is unexpected.
    send_byte(rspd_pkg::CH_PLUS);
    send_byte(rspd_pkg::CH_MINUS);
    send_byte(8'hFF);
    // Empty frame with checksum "00": accepted, the block now waits for an ACK.
    send_text("$#00");
    // A host NACK keeps the wait set, so the next frame is ignored even though
    // its digits are not hex; its payload byte is still forwarded.
    send_byte(rspd_pkg::CH_MINUS);
    send_byte(rspd_pkg::CH_DOLLAR);
    send_byte(8'hFF);
    send_text("#gg");
    send_byte(rspd_pkg::CH_PLUS);
    // Uppercase digit is bad hex; a valid but wrong checksum is a mismatch.
    send_text("$#A0");
    send_text("$#01");
    // Framing characters inside the payload are plain data: 24+2B+2D = 7c.
    send_text("$$+-#7c");

    // One long frame with no sender gaps.
    sender_gapless = 1'b1;
    send_byte(rspd_pkg::CH_PLUS);
    send_frame(LONG_FRAME_LEN, CK_GOOD);
    sender_gapless = 1'b0;

    // Random part, mostly well-formed frames with host replies, plus noise
    // and frames that break off. The long hold-off starts right away.
    hold_request = 1'b1;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      sender_gapless = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        case ($urandom_range(0, 19))
          0, 1, 2: kind = CK_WRONG;
          3, 4, 5: kind = CK_BAD;
          default: kind = CK_GOOD;
        endcase
        send_frame(($urandom_range(0, 19) == 0) ? $urandom_range(13, 200)
                                                : $urandom_range(0, 12), kind);
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 4) == 0) send_byte(rspd_pkg::CH_MINUS);
          send_byte(rspd_pkg::CH_PLUS);
        end
      end else if (r < 80) begin
        send_byte(($urandom_range(0, 1) == 0) ? rspd_pkg::CH_PLUS : rspd_pkg::CH_MINUS);
      end else if (r < 90) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // Broken frame: the bytes after it are parsed as whatever comes next.
        send_byte(rspd_pkg::CH_DOLLAR);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    rx_chan.valid <= 1'b0;

    // Drain: wait for every expected result, then a short tail so that a
    // surplus result would still be caught.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
